@@ design/rrfe_pkg.sv @@
// Shared types, constants and helper functions for the radial ripple field evaluator.
// No dependencies; every other design file uses this package.
`timescale 1ns / 1ps

package rrfe_pkg;

  // Pool and lifetime
  localparam int POOL_SIZE   = 2;
  localparam int LIFE_TICKS  = 32;
  localparam int IDX_W       = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
  localparam int CNT_W       = $clog2(POOL_SIZE + 1);
  localparam int AGE_W       = $clog2(LIFE_TICKS);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int FUNC_W = 2;
  localparam int TYPE_W = 4;
  localparam int LIFE_W = 8;
  localparam int X_W    = 15;
  localparam int Y_W    = 14;
  localparam int OUT_W  = 14;
  localparam int LIVE_W = 2;

  localparam logic [X_W-1:0]    MAX_X       = 15'd20480;
  localparam logic [Y_W-1:0]    MAX_Y       = 14'd11520;
  localparam logic [LIFE_W-1:0] EVENT_LIFE  = 8'd2;
  localparam logic [TYPE_W-1:0] TYPE_WEAK_A = 4'd0;
  localparam logic [TYPE_W-1:0] TYPE_WEAK_B = 4'd2;
  localparam logic [TYPE_W-1:0] TYPE_STRONG = 4'd9;

  // Datapath widths
  localparam int R16_MAX  = (24 + 13 * (LIFE_TICKS - 1)) * 16;
  localparam int R_W      = $clog2(R16_MAX + 1024 + 1);
  localparam int DX_W     = X_W + 1;
  localparam int D2_W     = 2 * X_W + 1;
  localparam int ROOT_W   = R_W + 4;
  localparam int V_W      = 2 * ROOT_W;
  localparam int SQ_STEPS = ROOT_W;
  localparam int RM_W     = ROOT_W + 3;
  localparam int DEN_W    = ROOT_W + 4;
  localparam int Q_W      = 17;
  localparam int P_W      = 20;
  localparam int NUM_W    = P_W + X_W;
  localparam int ACC_W    = NUM_W + 3;
  localparam int STEP_W   = $clog2(NUM_W + 1);

  localparam logic [P_W-1:0]  K_STRONG  = 20'd915893;
  localparam logic [P_W-1:0]  K_WEAK    = 20'd572433;
  localparam logic [Q_W-1:0]  Q_ONE     = 17'd65536;
  localparam logic [R_W-1:0]  BAND      = R_W'(1024);
  localparam int              SHIFT_LIM = 4096;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_EVENT = 2'd0,
    FUNC_TICK  = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_TICK,
    CMD_CLEAR,
    CMD_QUERY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t        op;
    logic           heavy;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;
  } cmd_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_TICK,
    BK_DXSQ,
    BK_D2,
    BK_INNER,
    BK_OUTER,
    BK_SQRT,
    BK_QUANT,
    BK_ENV,
    BK_P1,
    BK_P2,
    BK_P3,
    BK_DIV_LOAD,
    BK_DIV,
    BK_DIV_ACC,
    BK_RESULT
  } back_state_t;

  // Ring radius in 1/16 pixel
  function automatic logic [R_W-1:0] r16_of(logic [AGE_W-1:0] age);
    return R_W'((24 + 13 * int'(age)) * 16);
  endfunction

  // Linear fade over the ripple lifetime, Q16
  function automatic logic [Q_W-1:0] fade_of(logic [AGE_W-1:0] age);
    int f;
    f = 0;
    if (int'(age) < LIFE_TICKS) f = ((LIFE_TICKS - int'(age)) * 65536) / LIFE_TICKS;
    return Q_W'(f);
  endfunction

endpackage

@@ design/rrfe_if.sv @@
// Handshake channel interfaces: input items, result items and the configuration write.
// Depends on rrfe_pkg.
`timescale 1ns / 1ps

interface rrfe_in_if;
  logic                         valid;
  logic                         ready;
  logic [rrfe_pkg::FUNC_W-1:0]  func;
  logic                         scene_active;
  logic [rrfe_pkg::TYPE_W-1:0]  event_type;
  logic [rrfe_pkg::LIFE_W-1:0]  event_life;
  logic [rrfe_pkg::X_W-1:0]     pos_x;
  logic [rrfe_pkg::Y_W-1:0]     pos_y;
  modport source(output valid, func, scene_active, event_type, event_life, pos_x, pos_y,
                 input ready);
  modport sink(input valid, func, scene_active, event_type, event_life, pos_x, pos_y,
               output ready);
endinterface

interface rrfe_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [rrfe_pkg::OUT_W-1:0]  shift_x;
  logic signed [rrfe_pkg::OUT_W-1:0]  shift_y;
  logic [rrfe_pkg::LIVE_W-1:0]        live_ripples;
  modport source(output valid, shift_x, shift_y, live_ripples, input ready);
  modport sink(input valid, shift_x, shift_y, live_ripples, output ready);
endinterface

interface rrfe_cfg_if;
  logic valid;
  logic ready;
  logic ripples_enabled;
  modport source(output valid, ripples_enabled, input ready);
  modport sink(input valid, ripples_enabled, output ready);
endinterface

@@ design/rrfe_front.sv @@
// Front end: takes input requests and the enable register, sorts each request into a
// pool command and drops requests with no effect. Depends on rrfe_pkg and rrfe_if.
`timescale 1ns / 1ps

module rrfe_front (
  input  logic              clk,
  input  logic              rst_n,
  rrfe_in_if.sink           in_ch,
  rrfe_cfg_if.sink          cfg_ch,
  input  logic              queue_full,
  output logic              push,
  output rrfe_pkg::cmd_t    cmd
);
  import rrfe_pkg::*;

  logic    en_r;
  logic    en_nxt;
  logic    scene;
  logic    type_ok;
  logic    on_screen;
  logic    keep;
  func_t   func;

  // Enable register
  assign cfg_ch.ready = 1'b1;
  assign en_nxt = (cfg_ch.valid) ? cfg_ch.ripples_enabled : en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r <= 1'b0;
    end else begin
      en_r <= en_nxt;
    end
  end

  // Classify the request
  assign func      = func_t'(in_ch.func);
  assign scene     = en_r & in_ch.scene_active;
  assign type_ok   = (in_ch.event_type == TYPE_WEAK_A) || (in_ch.event_type == TYPE_WEAK_B) ||
                     (in_ch.event_type == TYPE_STRONG);
  assign on_screen = (in_ch.pos_x <= MAX_X) && (in_ch.pos_y <= MAX_Y);

  always_comb begin
    keep      = 1'b0;
    cmd.op    = CMD_QUERY;
    cmd.heavy = (in_ch.event_type == TYPE_STRONG);
    cmd.x     = (in_ch.pos_x > MAX_X) ? MAX_X : in_ch.pos_x;
    cmd.y     = (in_ch.pos_y > MAX_Y) ? MAX_Y : in_ch.pos_y;
    unique case (func)
      FUNC_EVENT: begin
        cmd.op = CMD_ADD;
        keep   = scene && (in_ch.event_life == EVENT_LIFE) && type_ok && on_screen;
      end
      FUNC_TICK: begin
        cmd.op = scene ? CMD_TICK : CMD_CLEAR;
        keep   = 1'b1;
      end
      FUNC_QUERY: begin
        cmd.op = CMD_QUERY;
        keep   = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // Accept whenever the queue has room; drop requests with no effect
  assign in_ch.ready = !queue_full;
  assign push        = in_ch.valid && !queue_full && keep;

endmodule

@@ design/rrfe_fifo.sv @@
// Short command queue between front end and back end.
// Depends on rrfe_pkg.
`timescale 1ns / 1ps

module rrfe_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rrfe_pkg::cmd_t    push_data,
  output logic              full,
  input  logic              pop,
  output rrfe_pkg::cmd_t    pop_data,
  output logic              not_empty
);
  import rrfe_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_r, wr_nxt;
  logic [QPTR_W-1:0] rd_r, rd_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign pop_data  = mem_r[rd_r];

  // Advance pointers and count
  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) wr_nxt = (wr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    if (do_pop)  rd_nxt = (rd_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    if (do_push && !do_pop) cnt_nxt = cnt_r + 1'b1;
    if (do_pop && !do_push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Hold queued commands
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_r] <= push_data;
  end

endmodule

@@ design/rrfe_back.sv @@
// Back end: ripple pool, tick sequencer and the query datapath (bit-serial square root,
// shared multiplier steps, one-bit-a-cycle divider) with the result register.
// Depends on rrfe_pkg and rrfe_if.
`timescale 1ns / 1ps

module rrfe_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rrfe_pkg::cmd_t    cmd,
  input  logic              cmd_valid,
  output logic              cmd_pop,
  rrfe_out_if.source        out_ch
);
  import rrfe_pkg::*;

  back_state_t               state_r, state_nxt;
  logic [CNT_W-1:0]          total_r, total_nxt;
  logic [CNT_W-1:0]          slot_r, slot_nxt;
  logic [X_W-1:0]            cx_r [POOL_SIZE];
  logic [X_W-1:0]            cx_nxt [POOL_SIZE];
  logic [Y_W-1:0]            cy_r [POOL_SIZE];
  logic [Y_W-1:0]            cy_nxt [POOL_SIZE];
  logic [AGE_W-1:0]          age_r [POOL_SIZE];
  logic [AGE_W-1:0]          age_nxt [POOL_SIZE];
  logic                      strong_r [POOL_SIZE];
  logic                      strong_nxt [POOL_SIZE];

  logic [X_W-1:0]            qx_r, qx_nxt;
  logic [Y_W-1:0]            qy_r, qy_nxt;
  logic signed [DX_W-1:0]    dx_r, dx_nxt;
  logic signed [DX_W-1:0]    dy_r, dy_nxt;
  logic [D2_W-1:0]           sq_r, sq_nxt;
  logic [D2_W-1:0]           d2_r, d2_nxt;
  logic                      inner_hit_r, inner_hit_nxt;
  logic [V_W-1:0]            v_r, v_nxt;
  logic [RM_W-1:0]           rem_r, rem_nxt;
  logic [ROOT_W-1:0]         root_r, root_nxt;
  logic [STEP_W-1:0]         step_r, step_nxt;
  logic                      qneg_r, qneg_nxt;
  logic [Q_W-1:0]            qmag_r, qmag_nxt;
  logic [Q_W-1:0]            env_r, env_nxt;
  logic [P_W-1:0]            p_r, p_nxt;
  logic                      axis_r, axis_nxt;
  logic [NUM_W-1:0]          dnum_r, dnum_nxt;
  logic [DEN_W:0]            drem_r, drem_nxt;
  logic [NUM_W-1:0]          dquo_r, dquo_nxt;
  logic                      dneg_r, dneg_nxt;
  logic signed [ACC_W-1:0]   accx_r, accx_nxt;
  logic signed [ACC_W-1:0]   accy_r, accy_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic signed [OUT_W-1:0]   sx_r, sx_nxt;
  logic signed [OUT_W-1:0]   sy_r, sy_nxt;
  logic [LIVE_W-1:0]         live_r, live_nxt;

  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          last;
  logic [IDX_W-1:0]          victim;
  logic [R_W-1:0]            r16;
  logic [R_W-1:0]            inner;
  logic [R_W-1:0]            outer;
  logic [2*R_W-1:0]          inner_sq;
  logic [2*R_W-1:0]          outer_sq;
  logic signed [DX_W-1:0]    dx_cur;
  logic [X_W-1:0]            dx_abs;
  logic [X_W-1:0]            dy_abs;
  logic [2*X_W-1:0]          dx_sq;
  logic [2*X_W-1:0]          dy_sq;
  logic [AGE_W:0]            aged;
  logic [CNT_W-1:0]          slot_inc;
  logic                      out_free;
  logic [RM_W-1:0]           sq_cur;
  logic [RM_W-1:0]           sq_trial;
  logic signed [ROOT_W+1:0]  qnum;
  logic [ROOT_W+1:0]         qabs;
  logic [ROOT_W+3:0]         qx4;
  logic [2*Q_W-1:0]          qsq;
  logic [P_W+Q_W-1:0]        pprod;
  logic [P_W-1:0]            kval;
  logic signed [DX_W-1:0]    dsel;
  logic [X_W-1:0]            dmag;
  logic [DEN_W:0]            dcur;
  logic [DEN_W-1:0]          den;
  logic signed [ACC_W-1:0]   contrib;

  function automatic logic signed [OUT_W-1:0] sat(logic signed [ACC_W-1:0] v);
    if (v > ACC_W'(SHIFT_LIM)) return OUT_W'(SHIFT_LIM);
    if (v < -ACC_W'(SHIFT_LIM)) return -OUT_W'(SHIFT_LIM);
    return v[OUT_W-1:0];
  endfunction

  assign idx      = slot_r[IDX_W-1:0];
  assign last     = IDX_W'(total_r - 1'b1);
  assign r16      = r16_of(age_r[idx]);
  assign inner    = (r16 > BAND) ? r16 - BAND : '0;
  assign outer    = r16 + BAND;
  assign inner_sq = inner * inner;
  assign outer_sq = outer * outer;
  assign aged     = {1'b0, age_r[idx]} + 1'b1;
  assign slot_inc = slot_r + 1'b1;
  assign out_free = !ovalid_r || out_ch.ready;
  assign den      = {root_r, 4'b0000};
  assign kval     = strong_r[idx] ? K_STRONG : K_WEAK;
  assign dsel     = axis_r ? dy_r : dx_r;
  assign dmag     = dsel[DX_W-1] ? X_W'(-dsel) : X_W'(dsel);

  // Offsets from the ripple centre and their squares
  assign dx_cur = $signed({1'b0, qx_r}) - $signed({1'b0, cx_r[idx]});
  assign dx_abs = dx_cur[DX_W-1] ? X_W'(-dx_cur) : X_W'(dx_cur);
  assign dy_abs = dy_r[DX_W-1] ? X_W'(-dy_r) : X_W'(dy_r);
  assign dx_sq  = dx_abs * dx_abs;
  assign dy_sq  = dy_abs * dy_abs;

  // Oldest ripple, ties to the lowest slot
  always_comb begin
    victim = '0;
    for (int i = 1; i < POOL_SIZE; i++) begin
      if (age_r[i] > age_r[victim]) victim = IDX_W'(i);
    end
  end

  // Square root step and quotient magnitude
  assign sq_cur   = {rem_r[RM_W-3:0], v_r[V_W-1:V_W-2]};
  assign sq_trial = {1'b0, root_r, 2'b01};
  assign qnum     = $signed({2'b00, root_r}) - $signed((ROOT_W+2)'({r16, 4'b0000}));
  assign qabs     = qnum[ROOT_W+1] ? (ROOT_W+2)'(-qnum) : (ROOT_W+2)'(qnum);
  assign qx4      = {qabs, 2'b00};
  assign qsq      = qmag_r * qmag_r;
  assign dcur     = {drem_r[DEN_W-1:0], dnum_r[NUM_W-1]};
  assign contrib  = dneg_r ? -$signed({3'b000, dquo_r}) : $signed({3'b000, dquo_r});

  // Shared multiplier operand select
  always_comb begin
    unique case (state_r)
      BK_QUANT: pprod = P_W'(kval) * fade_of(age_r[idx]);
      BK_P1:    pprod = p_r * qmag_r;
      default:  pprod = p_r * env_r;
    endcase
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    total_nxt     = total_r;
    slot_nxt      = slot_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    age_nxt       = age_r;
    strong_nxt    = strong_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    sq_nxt        = sq_r;
    d2_nxt        = d2_r;
    inner_hit_nxt = inner_hit_r;
    v_nxt         = v_r;
    rem_nxt       = rem_r;
    root_nxt      = root_r;
    step_nxt      = step_r;
    qneg_nxt      = qneg_r;
    qmag_nxt      = qmag_r;
    env_nxt       = env_r;
    p_nxt         = p_r;
    axis_nxt      = axis_r;
    dnum_nxt      = dnum_r;
    drem_nxt      = drem_r;
    dquo_nxt      = dquo_r;
    dneg_nxt      = dneg_r;
    accx_nxt      = accx_r;
    accy_nxt      = accy_r;
    ovalid_nxt    = ovalid_r && !out_ch.ready;
    sx_nxt        = sx_r;
    sy_nxt        = sy_r;
    live_nxt      = live_r;
    cmd_pop       = 1'b0;

    unique case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            CMD_ADD: begin
              if (total_r >= CNT_W'(POOL_SIZE)) begin
                cx_nxt[victim]     = cmd.x;
                cy_nxt[victim]     = cmd.y;
                age_nxt[victim]    = '0;
                strong_nxt[victim] = cmd.heavy;
              end else begin
                cx_nxt[total_r[IDX_W-1:0]]     = cmd.x;
                cy_nxt[total_r[IDX_W-1:0]]     = cmd.y;
                age_nxt[total_r[IDX_W-1:0]]    = '0;
                strong_nxt[total_r[IDX_W-1:0]] = cmd.heavy;
                total_nxt = total_r + 1'b1;
              end
            end
            CMD_TICK: begin
              slot_nxt  = '0;
              state_nxt = BK_TICK;
            end
            CMD_CLEAR: begin
              total_nxt = '0;
            end
            CMD_QUERY: begin
              qx_nxt    = cmd.x;
              qy_nxt    = cmd.y;
              accx_nxt  = '0;
              accy_nxt  = '0;
              slot_nxt  = '0;
              state_nxt = (total_r == '0) ? BK_RESULT : BK_DXSQ;
            end
            default: begin
              state_nxt = BK_IDLE;
            end
          endcase
        end
      end

      // Age one slot a cycle; a dropped slot is refilled from the last one and visited again
      BK_TICK: begin
        if (slot_r >= total_r) begin
          state_nxt = BK_IDLE;
        end else if (aged >= (AGE_W+1)'(LIFE_TICKS)) begin
          cx_nxt[idx]     = cx_r[last];
          cy_nxt[idx]     = cy_r[last];
          age_nxt[idx]    = age_r[last];
          strong_nxt[idx] = strong_r[last];
          total_nxt       = total_r - 1'b1;
        end else begin
          age_nxt[idx] = aged[AGE_W-1:0];
          slot_nxt     = slot_inc;
        end
      end

      BK_DXSQ: begin
        dx_nxt = dx_cur;
        dy_nxt = $signed(DX_W'({1'b0, qy_r})) - $signed(DX_W'({1'b0, cy_r[idx]}));
        sq_nxt = D2_W'(dx_sq);
        state_nxt = BK_D2;
      end

      BK_D2: begin
        d2_nxt    = sq_r + D2_W'(dy_sq);
        state_nxt = BK_INNER;
      end

      BK_INNER: begin
        inner_hit_nxt = d2_r <= D2_W'(inner_sq);
        state_nxt     = BK_OUTER;
      end

      // Skip ripples whose annulus misses the point, or whose centre is the point
      BK_OUTER: begin
        if (d2_r == '0 || inner_hit_r || d2_r >= D2_W'(outer_sq)) begin
          slot_nxt  = slot_inc;
          state_nxt = (slot_inc >= total_r) ? BK_RESULT : BK_DXSQ;
        end else begin
          v_nxt     = {d2_r[2*R_W-1:0], 8'h00};
          rem_nxt   = '0;
          root_nxt  = '0;
          step_nxt  = '0;
          state_nxt = BK_SQRT;
        end
      end

      // One root bit a cycle
      BK_SQRT: begin
        if (sq_cur >= sq_trial) begin
          rem_nxt  = sq_cur - sq_trial;
          root_nxt = {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_nxt  = sq_cur;
          root_nxt = {root_r[ROOT_W-2:0], 1'b0};
        end
        v_nxt    = {v_r[V_W-3:0], 2'b00};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(SQ_STEPS - 1)) state_nxt = BK_QUANT;
      end

      BK_QUANT: begin
        qneg_nxt  = qnum[ROOT_W+1];
        qmag_nxt  = (qx4 > (ROOT_W+4)'(Q_ONE)) ? Q_ONE : Q_W'(qx4);
        p_nxt     = P_W'(pprod >> 16);
        state_nxt = BK_ENV;
      end

      BK_ENV: begin
        env_nxt   = Q_ONE - Q_W'(qsq >> 16);
        state_nxt = BK_P1;
      end

      BK_P1: begin
        p_nxt     = P_W'(pprod >> 16);
        state_nxt = BK_P2;
      end

      BK_P2: begin
        p_nxt     = P_W'(pprod >> 16);
        state_nxt = BK_P3;
      end

      BK_P3: begin
        p_nxt     = P_W'(pprod >> 16);
        axis_nxt  = 1'b0;
        state_nxt = BK_DIV_LOAD;
      end

      BK_DIV_LOAD: begin
        dnum_nxt  = p_r * dmag;
        dneg_nxt  = qneg_r ^ dsel[DX_W-1];
        drem_nxt  = '0;
        dquo_nxt  = '0;
        step_nxt  = '0;
        state_nxt = BK_DIV;
      end

      // One quotient bit a cycle
      BK_DIV: begin
        if (dcur >= {1'b0, den}) begin
          drem_nxt = dcur - {1'b0, den};
          dquo_nxt = {dquo_r[NUM_W-2:0], 1'b1};
        end else begin
          drem_nxt = dcur;
          dquo_nxt = {dquo_r[NUM_W-2:0], 1'b0};
        end
        dnum_nxt = {dnum_r[NUM_W-2:0], 1'b0};
        step_nxt = step_r + 1'b1;
        if (step_r == STEP_W'(NUM_W - 1)) state_nxt = BK_DIV_ACC;
      end

      BK_DIV_ACC: begin
        if (!axis_r) begin
          accx_nxt  = accx_r + contrib;
          axis_nxt  = 1'b1;
          state_nxt = BK_DIV_LOAD;
        end else begin
          accy_nxt  = accy_r + contrib;
          slot_nxt  = slot_inc;
          state_nxt = (slot_inc >= total_r) ? BK_RESULT : BK_DXSQ;
        end
      end

      // Hold until the result register is free
      BK_RESULT: begin
        if (out_free) begin
          ovalid_nxt = 1'b1;
          sx_nxt     = sat(accx_r);
          sy_nxt     = sat(accy_r);
          live_nxt   = LIVE_W'(total_r);
          state_nxt  = BK_IDLE;
        end
      end

      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BK_IDLE;
      total_r  <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      total_r  <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    age_r       <= age_nxt;
    strong_r    <= strong_nxt;
    qx_r        <= qx_nxt;
    qy_r        <= qy_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    sq_r        <= sq_nxt;
    d2_r        <= d2_nxt;
    inner_hit_r <= inner_hit_nxt;
    v_r         <= v_nxt;
    rem_r       <= rem_nxt;
    root_r      <= root_nxt;
    step_r      <= step_nxt;
    qneg_r      <= qneg_nxt;
    qmag_r      <= qmag_nxt;
    env_r       <= env_nxt;
    p_r         <= p_nxt;
    axis_r      <= axis_nxt;
    dnum_r      <= dnum_nxt;
    drem_r      <= drem_nxt;
    dquo_r      <= dquo_nxt;
    dneg_r      <= dneg_nxt;
    accx_r      <= accx_nxt;
    accy_r      <= accy_nxt;
    sx_r        <= sx_nxt;
    sy_r        <= sy_nxt;
    live_r      <= live_nxt;
  end

  assign out_ch.valid        = ovalid_r;
  assign out_ch.shift_x      = sx_r;
  assign out_ch.shift_y      = sy_r;
  assign out_ch.live_ripples = live_r;

endmodule

@@ design/radial_ripple_field_evaluator.sv @@
// Radial ripple field evaluator top level: front end, command queue and back end.
// Depends on rrfe_pkg, rrfe_if, rrfe_front, rrfe_fifo and rrfe_back.
`timescale 1ns / 1ps

// The front end takes one request per cycle into a two-entry command queue while it has
// room; impact events and frame ticks need no result. The back end executes commands in
// order: an event is written straight into the pool, a tick ages each held ripple in
// turn, and a query takes every held ripple through setup states for the offsets, the
// squared distance and the inner and outer ring tests, a square root at one bit per
// cycle, 5 multiplier steps, then two bit-serial divides for x and y. The square root
// and the shared divider take most of a query's time. Ripples whose ring misses the
// query point skip the root and divides after the ring tests. The result sits in an
// output register, so the back end moves on to the next command while a result waits.

module radial_ripple_field_evaluator (
  input  logic        clk,
  input  logic        rst_n,
  rrfe_in_if.sink     in_ch,
  rrfe_out_if.source  out_ch,
  rrfe_cfg_if.sink    cfg_ch
);
  import rrfe_pkg::*;

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic full;
  logic pop;
  logic not_empty;

  rrfe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_ch     (cfg_ch),
    .queue_full (full),
    .push       (push),
    .cmd        (push_cmd)
  );

  rrfe_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_cmd),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_cmd),
    .not_empty (not_empty)
  );

  rrfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (pop_cmd),
    .cmd_valid (not_empty),
    .cmd_pop   (pop),
    .out_ch    (out_ch)
  );

endmodule

@@ dv/radial_ripple_field_evaluator_tb.sv @@
// Testbench for the radial ripple field evaluator: directed and random requests over
// several idle/stall phases, checked against an in-bench ripple pool predictor.
// Depends on rrfe_pkg, rrfe_if and the radial_ripple_field_evaluator design.
`timescale 1ns / 1ps

module radial_ripple_field_evaluator_tb;
  import rrfe_pkg::*;

  typedef struct {
    func_t       func;
    bit          scene;
    bit [3:0]    kind;
    bit [7:0]    life;
    bit [14:0]   x;
    bit [13:0]   y;
  } req_t;

  typedef struct {
    bit signed [13:0] sx;
    bit signed [13:0] sy;
    bit [1:0]         live;
  } shift_t;

  typedef struct {
    int unsigned cx [2];
    int unsigned cy [2];
    int unsigned age [2];
    bit          heavy [2];
    int unsigned total;
  } pool_t;

  logic clk;
  logic rst_n;

  rrfe_in_if  in_ch ();
  rrfe_out_if out_ch ();
  rrfe_cfg_if cfg_ch ();

  radial_ripple_field_evaluator dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source),
    .cfg_ch(cfg_ch.sink)
  );

  req_t   pending [$];
  shift_t expected_shifts [$];
  pool_t  model_pool;
  pool_t  plan_pool;
  bit     model_enabled;
  bit     plan_enabled;
  int     send_idle_pct;
  int     recv_stall_pct;
  int     errors;
  int     checked;
  int     requests_sent;

  // Integer square root, bit by bit
  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic longint part_of(longint unsigned pmag, bit pneg, longint d,
                                     longint unsigned rdist);
    bit              dneg;
    longint unsigned dmag;
    longint          mag;
    dneg = d < 0;
    dmag = dneg ? longint'(-d) : longint'(d);
    mag = longint'((pmag * dmag) / (rdist * 16));
    return (pneg != dneg) ? -mag : mag;
  endfunction

  function automatic longint clip_shift(longint v);
    if (v > SHIFT_LIM) return SHIFT_LIM;
    if (v < -SHIFT_LIM) return -SHIFT_LIM;
    return v;
  endfunction

  // Summed displacement of every held ripple at one point
  function automatic shift_t ripple_shift(pool_t p, int unsigned px, int unsigned py);
    shift_t          o;
    longint          ax, ay, dx, dy, num;
    longint unsigned d2, r16, inner, outer, rdist, qmag, env, fade, k, pm;
    bit              qneg;
    ax = 0;
    ay = 0;
    for (int i = 0; i < p.total && i < POOL_SIZE; i++) begin
      dx = longint'(px) - longint'(p.cx[i]);
      dy = longint'(py) - longint'(p.cy[i]);
      d2 = dx * dx + dy * dy;
      r16 = (24 + 13 * p.age[i]) * 16;
      inner = r16 > 1024 ? r16 - 1024 : 0;
      outer = r16 + 1024;
      if (d2 == 0 || d2 <= inner * inner || d2 >= outer * outer) continue;
      rdist = int_root(d2 * 256);
      if (rdist == 0) continue;
      num = longint'(rdist) - longint'(r16 * 16);
      qneg = num < 0;
      qmag = (qneg ? -num : num) * 4;
      if (qmag > 65536) qmag = 65536;
      env = 65536 - ((qmag * qmag) >> 16);
      fade = p.age[i] >= LIFE_TICKS ? 0 : ((LIFE_TICKS - p.age[i]) * 65536) / LIFE_TICKS;
      k = p.heavy[i] ? K_STRONG : K_WEAK;
      pm = (k * fade) >> 16;
      pm = (pm * qmag) >> 16;
      pm = (pm * env) >> 16;
      pm = (pm * env) >> 16;
      ax += part_of(pm, qneg, dx, rdist);
      ay += part_of(pm, qneg, dy, rdist);
    end
    o.sx = 14'(clip_shift(ax));
    o.sy = 14'(clip_shift(ay));
    o.live = 2'(p.total);
    return o;
  endfunction

  // Advance the pool by one request; return 1 when a query result is due
  function automatic bit pool_step(inout pool_t p, input bit en, input req_t r,
                                   output shift_t o);
    bit          live;
    int unsigned slot, i, last, px, py;
    live = en && r.scene;
    o = '{0, 0, 0};
    case (r.func)
      FUNC_EVENT: begin
        if (live && r.life == EVENT_LIFE &&
            (r.kind == TYPE_WEAK_A || r.kind == TYPE_WEAK_B || r.kind == TYPE_STRONG) &&
            r.x <= MAX_X && r.y <= MAX_Y) begin
          if (p.total >= POOL_SIZE) begin
            slot = 0;
            for (i = 1; i < POOL_SIZE; i++) if (p.age[i] > p.age[slot]) slot = i;
          end else begin
            slot = p.total;
            p.total++;
          end
          p.cx[slot] = r.x;
          p.cy[slot] = r.y;
          p.age[slot] = 0;
          p.heavy[slot] = r.kind == TYPE_STRONG;
        end
      end
      FUNC_TICK: begin
        if (!live) begin
          p.total = 0;
        end else begin
          i = 0;
          while (i < p.total) begin
            p.age[i]++;
            if (p.age[i] >= LIFE_TICKS) begin
              p.total--;
              last = p.total;
              p.cx[i] = p.cx[last];
              p.cy[i] = p.cy[last];
              p.age[i] = p.age[last];
              p.heavy[i] = p.heavy[last];
            end else begin
              i++;
            end
          end
        end
      end
      FUNC_QUERY: begin
        px = r.x > MAX_X ? MAX_X : r.x;
        py = r.y > MAX_Y ? MAX_Y : r.y;
        o = ripple_shift(p, px, py);
        return 1;
      end
      default: ;
    endcase
    return 0;
  endfunction

  // Queue a request and track the pool it leads to
  task automatic queue_req(func_t f, bit scene, bit [3:0] kind, bit [7:0] life,
                           bit [14:0] x, bit [13:0] y);
    req_t   r;
    shift_t o;
    r = '{f, scene, kind, life, x, y};
    pending.push_back(r);
    void'(pool_step(plan_pool, plan_enabled, r, o));
  endtask

  // Random request, mostly well formed, with queries aimed at ripple rings
  task automatic queue_random();
    int          pick, j, r16, target, dx, dy, qx, qy;
    bit [3:0]    kinds [3];
    kinds = '{TYPE_WEAK_A, TYPE_WEAK_B, TYPE_STRONG};
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      queue_req(FUNC_EVENT, 1, kinds[$urandom_range(0, 2)], EVENT_LIFE,
                15'($urandom_range(0, MAX_X)), 14'($urandom_range(0, MAX_Y)));
    end else if (pick < 30) begin
      // burst of ticks to age ripples out
      repeat ($urandom_range(4, 20)) queue_req(FUNC_TICK, 1, 0, 0, 0, 0);
    end else if (pick < 45) begin
      queue_req(FUNC_TICK, $urandom_range(0, 19) != 0, 4'($urandom), 8'($urandom),
                15'($urandom), 14'($urandom));
    end else if (pick < 88 && plan_pool.total > 0) begin
      j = $urandom_range(0, plan_pool.total - 1);
      r16 = (24 + 13 * plan_pool.age[j]) * 16;
      target = r16 + $urandom_range(0, 2200) - 1100;
      if (target < 1) target = 1;
      dx = $urandom_range(0, target);
      dy = int'(int_root(longint'(target) * target - longint'(dx) * dx));
      if ($urandom_range(0, 1)) dx = -dx;
      if ($urandom_range(0, 1)) dy = -dy;
      qx = int'(plan_pool.cx[j]) + dx;
      qy = int'(plan_pool.cy[j]) + dy;
      if (qx < 0) qx = 0;
      if (qy < 0) qy = 0;
      queue_req(FUNC_QUERY, $urandom_range(0, 1), 4'($urandom), 8'($urandom),
                15'(qx), 14'(qy));
    end else if (pick < 95) begin
      queue_req(FUNC_QUERY, $urandom_range(0, 1), 4'($urandom), 8'($urandom),
                15'($urandom), 14'($urandom));
    end else begin
      // noise: any field pattern, unused code included
      queue_req(func_t'($urandom_range(0, 3)), $urandom_range(0, 1), 4'($urandom),
                $urandom_range(0, 1) ? EVENT_LIFE : 8'($urandom), 15'($urandom),
                14'($urandom));
    end
  endtask

  // Drain all requests and results, then let the back end settle
  task automatic drain();
    while (pending.size() != 0 || in_ch.valid || expected_shifts.size() != 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_enable(bit value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.ripples_enabled <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    model_enabled = value;
    cfg_ch.valid <= 1'b0;
    plan_enabled = value;
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive the request channel from the pending queue
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req_t r;
        r = pending.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.func <= r.func;
        in_ch.scene_active <= r.scene;
        in_ch.event_type <= r.kind;
        in_ch.event_life <= r.life;
        in_ch.pos_x <= r.x;
        in_ch.pos_y <= r.y;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Stall the result channel at random
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= $urandom_range(0, 99) >= recv_stall_pct;
  end

  // Predict on accepted requests and check accepted results
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        req_t   r;
        shift_t o;
        r = '{func_t'(in_ch.func), in_ch.scene_active, in_ch.event_type, in_ch.event_life,
              in_ch.pos_x, in_ch.pos_y};
        requests_sent++;
        if (pool_step(model_pool, model_enabled, r, o)) expected_shifts.push_back(o);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_shifts.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d live=%0d", $time, out_ch.shift_x,
                   out_ch.shift_y, out_ch.live_ripples);
          errors++;
        end else begin
          shift_t e;
          e = expected_shifts.pop_front();
          checked++;
          if (out_ch.shift_x !== e.sx) begin
            $display("%0t: shift_x expected %0d actual %0d", $time, e.sx, out_ch.shift_x);
            errors++;
          end
          if (out_ch.shift_y !== e.sy) begin
            $display("%0t: shift_y expected %0d actual %0d", $time, e.sy, out_ch.shift_y);
            errors++;
          end
          if (out_ch.live_ripples !== e.live) begin
            $display("%0t: live_ripples expected %0d actual %0d", $time, e.live,
                     out_ch.live_ripples);
            errors++;
          end
        end
      end
    end
  end

  // Timeout
  initial begin
    #20ms;
    $display("status: fail");
    $finish;
  end

  // Stimulus
  initial begin
    int idle_pct [4];
    int stall_pct [4];
    bit en_cfg [4];
    int counts [4];
    idle_pct = '{0, 69, 0, 18};
    stall_pct = '{0, 0, 69, 18};
    en_cfg = '{1, 1, 0, 1};
    counts = '{140, 140, 50, 120};
    errors = 0;
    checked = 0;
    requests_sent = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    model_pool = '{default: 0, cx: '{0, 0}, cy: '{0, 0}, age: '{0, 0}, heavy: '{0, 0}};
    plan_pool = model_pool;
    model_enabled = 0;
    plan_enabled = 0;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_EVENT;
    in_ch.scene_active = 1'b0;
    in_ch.event_type = '0;
    in_ch.event_life = '0;
    in_ch.pos_x = '0;
    in_ch.pos_y = '0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.ripples_enabled = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Disabled: events are dropped, ticks clear
    queue_req(FUNC_EVENT, 1, TYPE_STRONG, EVENT_LIFE, 15'd100, 14'd100);
    queue_req(FUNC_QUERY, 1, 0, 0, 15'd400, 14'd100);
    queue_req(FUNC_TICK, 1, 0, 0, 0, 0);
    drain();
    write_enable(1'b1);

    // Enabled: screen corners, full pool, rejected events, clamps
    queue_req(FUNC_EVENT, 1, TYPE_WEAK_A, EVENT_LIFE, 15'd0, 14'd0);
    queue_req(FUNC_EVENT, 1, TYPE_STRONG, EVENT_LIFE, MAX_X, MAX_Y);
    queue_req(FUNC_QUERY, 1, 0, 0, 15'd0, 14'd0);
    queue_req(FUNC_QUERY, 0, 0, 0, 15'd384, 14'd0);
    queue_req(FUNC_QUERY, 1, 0, 0, 15'h7fff, 14'h3fff);
    queue_req(FUNC_QUERY, 1, 0, 0, MAX_X - 15'd300, MAX_Y - 14'd200);
    queue_req(FUNC_TICK, 1, 0, 0, 0, 0);
    queue_req(FUNC_EVENT, 1, TYPE_WEAK_B, EVENT_LIFE, 15'd8000, 14'd5000);
    queue_req(FUNC_QUERY, 1, 0, 0, 15'd8200, 14'd5300);
    queue_req(FUNC_EVENT, 1, TYPE_STRONG, 8'd3, 15'd50, 14'd50);
    queue_req(FUNC_EVENT, 1, 4'd5, EVENT_LIFE, 15'd50, 14'd50);
    queue_req(FUNC_EVENT, 1, 4'hf, 8'hff, 15'd50, 14'd50);
    queue_req(FUNC_EVENT, 1, TYPE_WEAK_A, EVENT_LIFE, MAX_X + 15'd1, 14'd50);
    queue_req(FUNC_EVENT, 1, TYPE_WEAK_A, EVENT_LIFE, 15'd50, MAX_Y + 14'd1);
    queue_req(FUNC_EVENT, 0, TYPE_WEAK_A, EVENT_LIFE, 15'd50, 14'd50);
    queue_req(FUNC_NONE, 1, TYPE_STRONG, EVENT_LIFE, 15'd50, 14'd50);
    queue_req(FUNC_QUERY, 1, 0, 0, 15'd50, 14'd600);
    queue_req(FUNC_TICK, 0, 0, 0, 0, 0);
    queue_req(FUNC_QUERY, 1, 0, 0, 15'd8200, 14'd5300);
    drain();

    // Random phases with different idle and stall mixes
    for (int ph = 0; ph < 4; ph++) begin
      write_enable(en_cfg[ph]);
      send_idle_pct = idle_pct[ph];
      recv_stall_pct = stall_pct[ph];
      repeat (counts[ph]) queue_random();
      drain();
    end

    $display("Sent %0d requests over four idle/stall phases, enable on and off;", requests_sent);
    $display("checked %0d query results.", checked);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
